// ----- hdl/b92_pkg.sv -----
// ----------------------------------------------------------------------------
// b92_pkg: shared types and constants of the base92 block encoder
// Block geometry, the reciprocal used for the divide by 92, the symbol
// table, the block type passed from the front to the back part and the result type.
// ----------------------------------------------------------------------------
package b92_pkg;

  localparam int BLK_BYTES = 13;           // input bytes per block
  localparam int BLK_CHARS = 16;           // output characters per block
  localparam int SYM_COUNT = 92;           // symbols in the alphabet
  localparam int RECIP_SHIFT = 16;         // v / 92 ~= (v * RECIP) >> 16
  localparam logic [9:0] RECIP = 10'd712;  // floor(2^16 / 92), never overshoots

  localparam int VAL_W = 13;               // width of one digit pair value
  localparam int SYM_W = 7;                // width of a symbol index / char

  // One gathered block: bytes zero padded past the stream end
  typedef struct packed {
    logic [BLK_BYTES-1:0][7:0] bytes;
    logic                      last;       // block closed by stream end
  } blk_t;

  // One result transaction
  typedef struct packed {
    logic [SYM_W-1:0] code_char;
    logic             block_last;
    logic             stream_last;
  } chr_t;

  // Symbol index to ASCII: 32 upward skipping '"', '&', '<', '>';
  // index 91 is tab and indexes 0 and 1 are swapped.
  function automatic logic [SYM_W-1:0] symbol_of(input logic [SYM_W-1:0] v);
    logic [SYM_W-1:0] c;
    c = 7'd32 + v;
    if (v >= 7'd2)  c = c + 7'd1;
    if (v >= 7'd5)  c = c + 7'd1;
    if (v >= 7'd26) c = c + 7'd1;
    if (v >= 7'd27) c = c + 7'd1;
    if (v == 7'd0) c = 7'd33;
    if (v == 7'd1) c = 7'd32;
    if (v >= 7'd91) c = 7'd9;
    return c;
  endfunction

endpackage

// ----- hdl/b92_front.sv -----
// ----------------------------------------------------------------------------
// b92_front: byte gatherer
// Collects input bytes into a 13-byte block and hands a closed block, zero
// padded after an early stream end, to the block queue.
// ----------------------------------------------------------------------------
module b92_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_push,
  output logic         in_full,
  input  logic [7:0]   in_data_byte,
  input  logic         in_stream_end,
  input  logic         q_full,
  output logic         q_push,
  output b92_pkg::blk_t q_blk
);
  import b92_pkg::*;

  logic [BLK_BYTES-1:0][7:0] bytes_r;
  logic [3:0]                count_r, count_nxt;
  logic                      accept;
  logic                      close;

  // accept while the queue can take a block
  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign close   = in_stream_end || (count_r == 4'(BLK_BYTES - 1));
  assign q_push  = accept && close;

  // assemble the closing block: held bytes, this byte, then zeros
  always_comb begin
    for (int j = 0; j < BLK_BYTES; j++) begin
      if (4'(j) < count_r)       q_blk.bytes[j] = bytes_r[j];
      else if (4'(j) == count_r) q_blk.bytes[j] = in_data_byte;
      else                       q_blk.bytes[j] = 8'h00;
    end
    q_blk.last = in_stream_end;
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (close) count_nxt = 4'd0;
      else       count_nxt = count_r + 4'd1;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 4'd0;
    else        count_r <= count_nxt;
  end

  // byte store, no reset needed: only positions below the count are read
  always_ff @(posedge clk) begin
    if (accept && !close) bytes_r[count_r] <= in_data_byte;
  end

endmodule

// ----- hdl/b92_blk_queue.sv -----
// ----------------------------------------------------------------------------
// b92_blk_queue: two-entry block queue
// Decouples the gatherer from the encoder so each side stalls on its own.
// ----------------------------------------------------------------------------
module b92_blk_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  b92_pkg::blk_t push_blk,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output b92_pkg::blk_t head_blk
);
  import b92_pkg::*;

  blk_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign head_blk = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_blk;
  end

endmodule

// ----- hdl/b92_back.sv -----
// ----------------------------------------------------------------------------
// b92_back: block encoder
// Walks the 16 characters of a block, one per cycle: digit pair select and
// reciprocal multiply, then remainder correction and symbol lookup into a
// four-entry result queue. Issue is held back by queue credit.
// ----------------------------------------------------------------------------
module b92_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  b92_pkg::blk_t               q_blk,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [b92_pkg::SYM_W-1:0]   out_code_char,
  output logic                        out_block_last,
  output logic                        out_stream_last
);
  import b92_pkg::*;

  // current block and character counter
  blk_t       cur_r;
  logic       busy_r;
  logic [3:0] k_r;

  // stage 1 registers
  logic             s1_valid_r;
  logic [VAL_W-1:0] s1_v_r;
  logic [SYM_W-1:0] s1_q_r;
  logic             s1_odd_r, s1_blast_r, s1_slast_r;

  // result queue
  chr_t       fifo_r [4];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] count_r;

  logic [5:0]       dig [BLK_CHARS];
  logic [2:0]       pair;
  logic [VAL_W-1:0] v;
  logic [22:0]      prod;
  logic             issue, load, last_char;
  logic [VAL_W-1:0] qm, rem;
  logic [SYM_W-1:0] q_fix, r_fix, sym;
  chr_t             wr_chr;
  logic             do_pop;

  function automatic logic [63:0] q_blk_word_a(input blk_t blk);
    return {blk.bytes[7], blk.bytes[6], blk.bytes[5], blk.bytes[4],
            blk.bytes[3], blk.bytes[2], blk.bytes[1], blk.bytes[0]};
  endfunction

  // split the block into sixteen 6-bit digits
  always_comb begin
    logic [63:0] a;
    logic [31:0] b;
    a = q_blk_word_a(cur_r);
    b = {cur_r.bytes[11], cur_r.bytes[10], cur_r.bytes[9], cur_r.bytes[8]};
    for (int i = 0; i < 10; i++) dig[i] = a[6*i +: 6];
    for (int i = 0; i < 5; i++)  dig[10+i] = b[6*i +: 6];
    dig[15] = {a[63:60], b[31:30]};
  end

  // digit pair value and quotient estimate
  assign pair = k_r[3:1];
  assign v    = {cur_r.bytes[12][pair], dig[{pair, 1'b1}], dig[{pair, 1'b0}]};
  assign prod = 23'(v) * 23'(RECIP);

  // issue control: credit covers the queue plus the stage in flight
  assign issue     = busy_r && ((count_r + 3'(s1_valid_r)) < 3'd4);
  assign last_char = (k_r == 4'(BLK_CHARS - 1));
  assign load      = q_valid && (!busy_r || (issue && last_char));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      k_r        <= 4'd0;
      s1_valid_r <= 1'b0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
        k_r    <= 4'd0;
      end else if (issue) begin
        k_r <= k_r + 4'd1;
        if (last_char) busy_r <= 1'b0;
      end
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (load) cur_r <= q_blk;
    if (issue) begin
      s1_v_r     <= v;
      s1_q_r     <= prod[RECIP_SHIFT +: SYM_W];
      s1_odd_r   <= k_r[0];
      s1_blast_r <= last_char;
      s1_slast_r <= last_char && cur_r.last;
    end
  end

  // stage 2: correct the quotient by one step, pick the symbol
  always_comb begin
    qm    = 13'(s1_q_r) * 13'(SYM_COUNT);
    rem   = s1_v_r - qm;
    q_fix = s1_q_r;
    r_fix = rem[SYM_W-1:0];
    if (rem >= 13'(SYM_COUNT)) begin
      q_fix = s1_q_r + 7'd1;
      r_fix = 7'(rem - 13'(SYM_COUNT));
    end
    sym = s1_odd_r ? q_fix : r_fix;
    wr_chr.code_char   = symbol_of(sym);
    wr_chr.block_last  = s1_blast_r;
    wr_chr.stream_last = s1_slast_r;
  end

  // result queue
  assign out_empty       = (count_r == 3'd0);
  assign do_pop          = out_pop && !out_empty;
  assign out_code_char   = fifo_r[rd_ptr_r].code_char;
  assign out_block_last  = fifo_r[rd_ptr_r].block_last;
  assign out_stream_last = fifo_r[rd_ptr_r].stream_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (s1_valid_r) wr_ptr_r <= wr_ptr_r + 2'd1;
      if (do_pop)     rd_ptr_r <= rd_ptr_r + 2'd1;
      case ({s1_valid_r, do_pop})
        2'b10:   count_r <= count_r + 3'd1;
        2'b01:   count_r <= count_r - 3'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) fifo_r[wr_ptr_r] <= wr_chr;
  end

endmodule

// ----- hdl/base92_block_encoder.sv -----
// ----------------------------------------------------------------------------
// base92_block_encoder: 13-byte to 16-character base92 encoder
// Gathers bytes into blocks and emits each block as 16 printable characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue port: push a byte with in_push while in_full is low; mark the
//   final byte of a stream with in_stream_end. A block closes at its 13th
//   byte or at the stream end (the rest is padded with zero bytes).
//   Result queue port: while out_empty is low the oldest character is on
//   out_code_char; out_block_last flags the 16th character of a block and
//   out_stream_last the last character of a stream. Take it with out_pop.
//   After the transaction that closes a block, its first character passes the
//   block queue, the encoder's block register and stage 1 registers, and the
//   result queue. Throughput: one character per cycle while the result queue
//   has room; the sustained input rate is set by the one-character result port.
//   Input bytes go in one per cycle while the two-entry block queue has room.
//   Reset (synchronous, rst_n low) empties both queues and drops a partly
//   gathered block. When the receiver stalls, the four-entry result queue
//   fills, encoding pauses, then the block queue fills and in_full rises.
// ----------------------------------------------------------------------------
module base92_block_encoder (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_push,
  output logic                      in_full,
  input  logic [7:0]                in_data_byte,
  input  logic                      in_stream_end,
  output logic                      out_empty,
  input  logic                      out_pop,
  output logic [b92_pkg::SYM_W-1:0] out_code_char,
  output logic                      out_block_last,
  output logic                      out_stream_last
);
  import b92_pkg::*;

  logic q_full, q_push, q_valid, q_pop;
  blk_t push_blk, head_blk;

  // byte gatherer
  b92_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_blk         (push_blk)
  );

  // block queue between front and back
  b92_blk_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_blk (push_blk),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_blk (head_blk)
  );

  // encoder and result queue
  b92_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_blk           (head_blk),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_code_char   (out_code_char),
    .out_block_last  (out_block_last),
    .out_stream_last (out_stream_last)
  );

endmodule

// ----- hdl/b92_checker.sv -----
// ----------------------------------------------------------------------------
// b92_checker: port-level checks of the base92 block encoder
// Watches the top-level ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module b92_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_full,
  input logic                      out_empty,
  input logic                      out_pop,
  input logic [b92_pkg::SYM_W-1:0] out_code_char,
  input logic                      out_block_last,
  input logic                      out_stream_last
);
  import b92_pkg::*;

  // both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // a stream ends only on the last character of a block
  a_stream_on_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_stream_last) |-> out_block_last)
    else $error("stream_last without block_last");

  // every character is from the 92-symbol alphabet
  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ((out_code_char == 7'd9 || out_code_char >= 7'd32) &&
                    out_code_char != 7'd34 && out_code_char != 7'd38 &&
                    out_code_char != 7'd60 && out_code_char != 7'd62 &&
                    out_code_char <= 7'd126))
    else $error("character outside the alphabet");

  // a waiting result holds while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_code_char) &&
                                  $stable(out_block_last) &&
                                  $stable(out_stream_last)))
    else $error("stalled result changed");

endmodule

bind base92_block_encoder b92_checker u_b92_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_full         (in_full),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_code_char   (out_code_char),
  .out_block_last  (out_block_last),
  .out_stream_last (out_stream_last)
);
